// ===== sv/rope_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rope_pkg
// shared types, constants and constant tables of the rotary position
// embedding unit
// ----------------------------------------------------------------------------
package rope_pkg;

	localparam int SAMPLE_BITS          = 16;
	localparam int POSITION_BITS        = 16;
	localparam int DEF_MAX_HEAD_LENGTH  = 128;
	localparam int DEF_CORDIC_STEPS     = 16;

	localparam int INDEX_BITS     = 7;
	localparam int CFG_DATA_BITS  = 24;
	localparam int CFG_INDEX_BITS = 3;
	localparam int STEP_FRAC_BITS = 20;
	localparam int ATAN_ENTRIES   = 24;

	// register map
	localparam logic [CFG_INDEX_BITS-1:0] REG_HEAD_LENGTH  = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_ROTARY_DIMS  = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_INTERLEAVED  = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_NEGATE_SINE  = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FREQ_STEP    = 3'd4;

	// cordic datapath width, Q2.30 values with headroom
	localparam int CW     = 34;
	localparam int PROD_W = SAMPLE_BITS + CW;
	localparam int SUM_W  = PROD_W + 1;

	localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);
	localparam logic [29:0] INV_TWO_PI = 30'd683565276;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] in_value;
		logic [POSITION_BITS-1:0]      position;
	} rope_in_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] out_value;
		logic [INDEX_BITS-1:0]         element_index;
		logic                          last_of_run;
	} rope_out_t;

	// arctangent of 2^-j in turns, Q.32
	localparam logic [0:ATAN_ENTRIES-1][31:0] ATAN_TURNS = {
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
		32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	typedef logic [0:STEP_FRAC_BITS-1][31:0] root_tab_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] vv;
		logic [63:0] res;
		logic [63:0] bw;
		vv  = v;
		res = '0;
		bw  = 64'd1 << 62;
		while (bw > vv) bw = bw >> 2;
		while (bw != 64'd0) begin
			if (vv >= res + bw) begin
				vv  = vv - (res + bw);
				res = (res >> 1) + bw;
			end else begin
				res = res >> 1;
			end
			bw = bw >> 2;
		end
		return res;
	endfunction

	// successive square roots of one half, Q.32: 2^-(2^-(t+1))
	function automatic root_tab_t build_roots();
		root_tab_t   tab;
		logic [63:0] r;
		r = 64'd1 << 31;
		for (int t = 0; t < STEP_FRAC_BITS; t++) begin
			r = isqrt64(r << 32);
			tab[t] = r[31:0];
		end
		return tab;
	endfunction

	localparam root_tab_t MANT_ROOT = build_roots();

	// round Q.42 to Q.12 and saturate
	function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
		input logic signed [SUM_W-1:0] v
	);
		logic signed [SUM_W-1:0] r;
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = SUM_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
		lo = -hi - SUM_W'(1);
		r  = (v + (SUM_W'(1) <<< 29)) >>> 30;
		if (r > hi) return hi[SAMPLE_BITS-1:0];
		else if (r < lo) return lo[SAMPLE_BITS-1:0];
		else return r[SAMPLE_BITS-1:0];
	endfunction

endpackage

// ===== sv/rotary_position_embedding_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotary_position_embedding_unit
// streamed rotary position embedding over head rows, Q3.12 fixed point
// ----------------------------------------------------------------------------
// Elements of a head row enter one word at a time with the row's token
// position; an internal counter numbers them. An element at or beyond the
// rotary dimensions leaves as one result word in the cycle after it is taken,
// and a first half of a pair is parked in the pending memory with no result;
// both leave the sequencer idle. The second half of a pair starts the angle
// path: an exponent multiply, a mantissa loop (one root multiply per fraction
// bit), the angle product, its shift and the two phase products, quadrant
// reduction, CORDIC_STEPS steps on the shared cordic stage, a mapping step
// and a product step. The first rotated word is loaded from ST_EMT0 and the
// second from ST_EMT1, each once the output register is free, and the next
// input word is taken once both have been handed over. The output register
// holds one finished word; a pass-through element is taken as soon as that
// register is empty or being read. The pending memory has no reset and needs
// no clearing.
// ----------------------------------------------------------------------------
module rotary_position_embedding_unit import rope_pkg::*; #(
	parameter int MAX_HEAD_LENGTH = DEF_MAX_HEAD_LENGTH,
	parameter int CORDIC_STEPS    = DEF_CORDIC_STEPS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  rope_in_t                  in_word,
	output logic                      out_valid,
	input  logic                      out_stall,
	output rope_out_t                 out_word,
	input  logic                      cfg_write,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

	localparam int PEND_DEPTH = MAX_HEAD_LENGTH / 2;
	localparam int PEND_AW    = (PEND_DEPTH > 1) ? $clog2(PEND_DEPTH) : 1;
	localparam int APW        = POSITION_BITS + 33;   // position times Q1.32 mantissa

	// sequencer codes
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_EXPO = 4'd1;
	localparam logic [3:0] ST_MANT = 4'd2;
	localparam logic [3:0] ST_ANGL = 4'd3;
	localparam logic [3:0] ST_SHFT = 4'd4;
	localparam logic [3:0] ST_PHLO = 4'd5;
	localparam logic [3:0] ST_PHHI = 4'd6;
	localparam logic [3:0] ST_CINI = 4'd7;
	localparam logic [3:0] ST_CORD = 4'd8;
	localparam logic [3:0] ST_CMAP = 4'd9;
	localparam logic [3:0] ST_MULT = 4'd10;
	localparam logic [3:0] ST_EMT0 = 4'd11;
	localparam logic [3:0] ST_EMT1 = 4'd12;

	// configuration registers
	logic [7:0]  head_length_q;
	logic [7:0]  rotary_dims_q;
	logic        interleaved_q;
	logic        negate_sine_q;
	logic [23:0] freq_step_q;

	logic [3:0]            state_q;
	logic [INDEX_BITS-1:0] cnt_q;
	logic                  out_valid_q;
	rope_out_t             out_word_q;

	// item registers
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic [POSITION_BITS-1:0]      pos_q;
	logic [INDEX_BITS-1:0]         pair_q;
	logic [INDEX_BITS-1:0]         ia_q;
	logic [INDEX_BITS-1:0]         e_q;

	// angle path
	logic [30:0]                expo_q;
	logic [STEP_FRAC_BITS-1:0]  frac_q;
	logic [4:0]                 t_q;
	logic [32:0]                m_q;
	logic [APW-1:0]             aprod_q;
	logic [APW-1:0]             ang_q;
	logic [61:0]                lo_q;
	logic [31:0]                phase_q;
	logic [1:0]                 quad_q;
	logic signed [CW-1:0]       cx_q, cy_q, cz_q;
	logic [4:0]                 j_q;
	logic signed [CW-1:0]       c_q, s_q;
	logic signed [PROD_W-1:0]   pa_q, pb_q;

	// pending first halves
	logic [SAMPLE_BITS-1:0] pend_mem [PEND_DEPTH];
	logic signed [SAMPLE_BITS-1:0] pend_rdata;

	// --- element classification against current settings ---
	logic [7:0]            hl_eff, rd_even, rd_eff, half, e8;
	logic                  pass, first;
	logic [INDEX_BITS-1:0] pair, ia, cnt_next;
	logic                  out_free, in_acc, out_load;
	logic                  pend_we, pend_re;

	always_comb begin
		if (head_length_q < 8'd2) hl_eff = 8'd2;
		else if (head_length_q > 8'(MAX_HEAD_LENGTH)) hl_eff = 8'(MAX_HEAD_LENGTH);
		else hl_eff = head_length_q;
		rd_even = {rotary_dims_q[7:1], 1'b0};
		rd_eff  = (rd_even > hl_eff) ? hl_eff : rd_even;
		half    = rd_eff >> 1;
		e8      = {1'b0, cnt_q};
		pass    = (e8 >= rd_eff);
		if (interleaved_q) begin
			first = ~cnt_q[0];
			pair  = cnt_q >> 1;
			ia    = {cnt_q[INDEX_BITS-1:1], 1'b0};
		end else begin
			first = (e8 < half);
			pair  = first ? cnt_q : (cnt_q - half[INDEX_BITS-1:0]);
			ia    = pair;
		end
		cnt_next = ((e8 + 8'd1) >= hl_eff) ? '0 : (cnt_q + 7'd1);
	end

	assign out_free = ~out_valid_q | ~out_stall;
	assign in_stall = ~((state_q == ST_IDLE) & out_free);
	assign in_acc   = in_valid & ~in_stall;
	assign pend_we  = in_acc & ~pass & first;
	assign pend_re  = in_acc & ~pass & ~first;
	// a word enters the output register: pass-through or either rotated word
	assign out_load = (in_acc & pass) |
		(((state_q == ST_EMT0) | (state_q == ST_EMT1)) & out_free);

	// pending memory with registered read; read data stays until next read
	always_ff @(posedge clk) begin
		if (pend_we) pend_mem[pair[PEND_AW-1:0]] <= in_word.in_value;
		if (pend_re) pend_rdata <= pend_mem[pair[PEND_AW-1:0]];
	end

	// --- arithmetic helpers ---
	logic [30:0]           expo_w;
	logic [64:0]           mprod_w;
	logic [APW-1:0]        aprod_w;
	logic [61:0]           lo_w;
	logic [APW-32+29:0]    hi_w;
	logic [31:0]           qsum_w, zr_w;
	logic signed [CW-1:0]  xs_w, ys_w, at_w;
	logic signed [CW-1:0]  cm_w, sm_w;
	logic signed [SUM_W-1:0] diff_w, sum_w;

	always_comb begin
		expo_w  = 31'(pair_q) * 31'(freq_step_q);
		mprod_w = 65'(m_q) * 65'(MANT_ROOT[t_q]);
		aprod_w = APW'(pos_q) * APW'(m_q);
		lo_w    = 62'(ang_q[31:0]) * 62'(INV_TWO_PI);
		hi_w    = (APW-2)'(ang_q[APW-1:32]) * (APW-2)'(INV_TWO_PI);
		qsum_w  = phase_q + 32'h2000_0000;
		zr_w    = phase_q - {qsum_w[31:30], 30'd0};
		xs_w    = cx_q >>> j_q;
		ys_w    = cy_q >>> j_q;
		at_w    = CW'(ATAN_TURNS[j_q]);
		// map the first quadrant result back
		case (quad_q)
			2'd0:    begin cm_w = cx_q;  sm_w = cy_q;  end
			2'd1:    begin cm_w = -cy_q; sm_w = cx_q;  end
			2'd2:    begin cm_w = -cx_q; sm_w = -cy_q; end
			default: begin cm_w = cy_q;  sm_w = -cx_q; end
		endcase
		if (negate_sine_q) sm_w = -sm_w;
		diff_w = SUM_W'(pa_q) - SUM_W'(pb_q);
		sum_w  = SUM_W'(pa_q) + SUM_W'(pb_q);
	end

	// --- sequencer and control state ---
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cnt_q         <= '0;
			out_valid_q   <= 1'b0;
			head_length_q <= 8'd64;
			rotary_dims_q <= 8'd64;
			interleaved_q <= 1'b0;
			negate_sine_q <= 1'b0;
			freq_step_q   <= 24'd435413;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					REG_HEAD_LENGTH: head_length_q <= cfg_data[7:0];
					REG_ROTARY_DIMS: rotary_dims_q <= cfg_data[7:0];
					REG_INTERLEAVED: interleaved_q <= cfg_data[0];
					REG_NEGATE_SINE: negate_sine_q <= cfg_data[0];
					REG_FREQ_STEP:   freq_step_q   <= cfg_data;
					default: ;
				endcase
			end
			// output word stays until read, unless a new one is loaded
			out_valid_q <= out_load | (out_valid_q & out_stall);
			unique case (state_q)
				ST_IDLE: if (in_acc) begin
					cnt_q <= cnt_next;
					if (!pass && !first) state_q <= ST_EXPO;
				end
				ST_EXPO: state_q <= ST_MANT;
				ST_MANT: if (t_q == 5'(STEP_FRAC_BITS - 1)) state_q <= ST_ANGL;
				ST_ANGL: state_q <= ST_SHFT;
				ST_SHFT: state_q <= ST_PHLO;
				ST_PHLO: state_q <= ST_PHHI;
				ST_PHHI: state_q <= ST_CINI;
				ST_CINI: state_q <= ST_CORD;
				ST_CORD: if (j_q == 5'(CORDIC_STEPS - 1)) state_q <= ST_CMAP;
				ST_CMAP: state_q <= ST_MULT;
				ST_MULT: state_q <= ST_EMT0;
				ST_EMT0: if (out_free) state_q <= ST_EMT1;
				ST_EMT1: if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// --- datapath registers ---
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (in_acc) begin
				x_q    <= in_word.in_value;
				pos_q  <= in_word.position;
				pair_q <= pair;
				ia_q   <= ia;
				e_q    <= cnt_q;
				if (pass) out_word_q <= '{out_value: in_word.in_value,
					element_index: cnt_q, last_of_run: 1'b1};
			end
			ST_EXPO: begin
				expo_q <= expo_w;
				frac_q <= expo_w[STEP_FRAC_BITS-1:0];
				m_q    <= 33'h1_0000_0000;
				t_q    <= '0;
			end
			ST_MANT: begin
				// one fraction bit per cycle, msb first
				if (frac_q[STEP_FRAC_BITS-1]) m_q <= mprod_w[64:32];
				frac_q <= frac_q << 1;
				t_q    <= t_q + 5'd1;
			end
			ST_ANGL: aprod_q <= aprod_w;
			ST_SHFT: ang_q <= (|expo_q[30:26]) ? '0 : (aprod_q >> expo_q[25:20]);
			ST_PHLO: lo_q <= lo_w;
			ST_PHHI: phase_q <= hi_w[31:0] + {2'd0, lo_q[61:32]};
			ST_CINI: begin
				quad_q <= qsum_w[31:30];
				cz_q   <= CW'($signed(zr_w));
				cx_q   <= CORDIC_GAIN;
				cy_q   <= '0;
				j_q    <= '0;
			end
			ST_CORD: begin
				if (!cz_q[CW-1]) begin
					cx_q <= cx_q - ys_w;
					cy_q <= cy_q + xs_w;
					cz_q <= cz_q - at_w;
				end else begin
					cx_q <= cx_q + ys_w;
					cy_q <= cy_q - xs_w;
					cz_q <= cz_q + at_w;
				end
				j_q <= j_q + 5'd1;
			end
			ST_CMAP: begin
				c_q <= cm_w;
				s_q <= sm_w;
			end
			ST_MULT: begin
				pa_q <= PROD_W'(pend_rdata) * PROD_W'(c_q);
				pb_q <= PROD_W'(x_q) * PROD_W'(s_q);
			end
			ST_EMT0: if (out_free) begin
				out_word_q <= '{out_value: round_sat(diff_w), element_index: ia_q,
					last_of_run: 1'b0};
				pa_q <= PROD_W'(pend_rdata) * PROD_W'(s_q);
				pb_q <= PROD_W'(x_q) * PROD_W'(c_q);
			end
			ST_EMT1: if (out_free) begin
				out_word_q <= '{out_value: round_sat(sum_w), element_index: e_q,
					last_of_run: 1'b1};
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// input is only taken while the sequencer is free
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> state_q == ST_IDLE)
		else $error("input taken while pair in progress");

	// first rotated word is never the last of its run
	a_first_word: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMT0 && out_free) |=> out_valid && !out_word.last_of_run)
		else $error("first rotated word flagged last");

	// second rotated word closes the run and frees the sequencer
	a_second_word: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMT1 && out_free) |=>
			out_valid && out_word.last_of_run && state_q == ST_IDLE)
		else $error("second rotated word lost");

endmodule

// ===== tb/sv/rotary_position_embedding_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotary_position_embedding_unit_tb
// self-checking bench for the streamed rotary position embedding unit
// ----------------------------------------------------------------------------
// Whole head rows are streamed under a series of register settings. A
// scoreboard object mirrors the pairing store, the element counter and the
// fixed point angle / cordic arithmetic, and checks every result word in order.
// ----------------------------------------------------------------------------
module rotary_position_embedding_unit_tb;
	import rope_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 120;

	class rope_scoreboard;
		logic [7:0]  head_length;
		logic [7:0]  rotary_dims;
		logic        interleaved;
		logic        negate_sine;
		logic [23:0] freq_step;
		longint      first_halves[64];
		int unsigned elem_count;
		logic [31:0] roots[20];
		logic [31:0] atan_turns[16];
		rope_out_t   expected_words[$];
		int          errors;
		int          words_checked;
		int          pairs_rotated;

		function new();
			logic [63:0] r;
			head_length = 64;
			rotary_dims = 64;
			interleaved = 0;
			negate_sine = 0;
			freq_step   = 24'd435413;
			elem_count  = 0;
			errors = 0;
			words_checked = 0;
			pairs_rotated = 0;
			foreach (first_halves[i]) first_halves[i] = 0;
			atan_turns = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
				32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
				32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
				32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D};
			// successive square roots of one half
			r = 64'd1 << 31;
			for (int t = 0; t < 20; t++) begin
				r = sqrt_floor(r << 32);
				roots[t] = r[31:0];
			end
		endfunction

		function logic [63:0] sqrt_floor(logic [63:0] v);
			logic [63:0] res;
			logic [63:0] cand;
			res = 0;
			for (int b = 31; b >= 0; b--) begin
				cand = res | (64'd1 << b);
				if (cand * cand <= v) res = cand;
			end
			return res;
		endfunction

		function void set_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] d);
			case (idx)
				REG_HEAD_LENGTH: head_length = d[7:0];
				REG_ROTARY_DIMS: rotary_dims = d[7:0];
				REG_INTERLEAVED: interleaved = d[0];
				REG_NEGATE_SINE: negate_sine = d[0];
				REG_FREQ_STEP:   freq_step   = d;
				default: ;
			endcase
		endfunction

		// angle of pair at position, in turns as a 32 bit fraction
		function logic [31:0] phase_of(logic [63:0] pair, logic [63:0] pos);
			logic [63:0] ex, k, f, m, a, hi, lo, ph;
			ex = pair * freq_step;
			k  = ex >> 20;
			f  = ex & 64'hFFFFF;
			m  = 64'd1 << 32;
			for (int t = 0; t < 20; t++)
				if (f[19-t]) m = (m * roots[t]) >> 32;
			a  = (k >= 64) ? 64'd0 : ((pos * m) >> k);
			hi = a >> 32;
			lo = a & 64'hFFFFFFFF;
			ph = hi * 64'd683565276 + ((lo * 64'd683565276) >> 32);
			return ph[31:0];
		endfunction

		function void cos_sin(logic [31:0] ph, output longint c, output longint s);
			logic [31:0] q, zr;
			longint z, x, y, nx;
			q  = ((ph + 32'h20000000) >> 30) & 32'd3;
			zr = ph - (q << 30);
			z  = longint'($signed(zr));
			x  = 652032874;
			y  = 0;
			for (int j = 0; j < 16; j++) begin
				if (z >= 0) begin
					nx = x - (y >>> j);
					y  = y + (x >>> j);
					z  = z - longint'(atan_turns[j]);
				end else begin
					nx = x + (y >>> j);
					y  = y - (x >>> j);
					z  = z + longint'(atan_turns[j]);
				end
				x = nx;
			end
			case (q)
				0: begin c = x;  s = y;  end
				1: begin c = -y; s = x;  end
				2: begin c = -x; s = -y; end
				default: begin c = y; s = -x; end
			endcase
		endfunction

		function logic [15:0] to_sample(longint v);
			longint r;
			r = (v + (longint'(1) <<< 29)) >>> 30;
			if (r > 32767) r = 32767;
			if (r < -32768) r = -32768;
			return r[15:0];
		endfunction

		function void push(logic [15:0] v, int unsigned idx, logic last);
			rope_out_t w;
			w.out_value     = v;
			w.element_index = idx[6:0];
			w.last_of_run   = last;
			expected_words.push_back(w);
		endfunction

		function void note_input(rope_in_t w);
			int unsigned hl, rd, half, e, pair, ia;
			logic first;
			longint x, x1, c, s;
			hl = (head_length < 2) ? 2 : ((head_length > 128) ? 128 : head_length);
			rd = rotary_dims & 8'hFE;
			if (rd > hl) rd = hl;
			half = rd / 2;
			e = elem_count;
			x = longint'(w.in_value);
			if (e >= rd) begin
				push(w.in_value, e, 1'b1);
			end else begin
				if (interleaved) begin
					first = (e % 2) == 0;
					pair  = e / 2;
					ia    = pair * 2;
				end else begin
					first = e < half;
					pair  = first ? e : e - half;
					ia    = pair;
				end
				if (first) begin
					first_halves[pair % 64] = x;
				end else begin
					x1 = first_halves[pair % 64];
					cos_sin(phase_of(pair, w.position), c, s);
					if (negate_sine) s = -s;
					push(to_sample(x1 * c - x * s), ia, 1'b0);
					push(to_sample(x1 * s + x * c), e, 1'b1);
					pairs_rotated++;
				end
			end
			elem_count = (e + 1 >= hl) ? 0 : ((e + 1) & 32'h7F);
		endfunction

		function void check(rope_out_t got);
			rope_out_t want;
			words_checked++;
			if (expected_words.size() == 0) begin
				$error("unexpected result word %h", got);
				errors++;
				return;
			end
			want = expected_words.pop_front();
			if (got.out_value !== want.out_value) begin
				$error("out_value expected %0d got %0d", want.out_value, got.out_value);
				errors++;
			end
			if (got.element_index !== want.element_index) begin
				$error("element_index expected %0d got %0d",
					want.element_index, got.element_index);
				errors++;
			end
			if (got.last_of_run !== want.last_of_run) begin
				$error("last_of_run expected %0d got %0d", want.last_of_run, got.last_of_run);
				errors++;
			end
		endfunction

		function int unsigned row_len();
			return (head_length < 2) ? 2 : ((head_length > 128) ? 128 : head_length);
		endfunction
	endclass

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	rope_in_t                  in_word;
	logic                      out_valid;
	logic                      out_stall;
	rope_out_t                 out_word;
	logic                      cfg_write;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;

	rope_scoreboard sb;
	int  items_sent;
	int  phases_run;
	int  idle_cycles;
	bit  no_gaps;     // stretches with no idling on either side
	bit  long_hold;   // receiver holds off for a long stretch on its next word

	rotary_position_embedding_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_word  (in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word (out_word),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// watchdog: cycles with no word moving on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[rotary_position_embedding_unit] ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// receiver: random hold-off per word, checked at the accepting edge
	initial begin
		int n;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			n = no_gaps ? 0 : $urandom_range(0, 4);
			if (long_hold) begin
				n = 600;
				long_hold = 0;
			end
			if (n > 0) begin
				out_stall = 1'b1;
				repeat (n) @(negedge clk);
			end
			out_stall = 1'b0;
			do @(posedge clk); while (!out_valid);
			sb.check(out_word);
		end
	end

	// called at a falling edge, returns at a falling edge with valid still high
	task automatic send_word(input rope_in_t w);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		in_word  = w;
		do @(posedge clk); while (in_stall);
		sb.note_input(w);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] d);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data  = d;
		@(posedge clk);
		sb.set_reg(idx, d);
		@(negedge clk);
		cfg_write = 1'b0;
	endtask

	// all results in, then room for a first half still being parked
	task automatic wait_drained();
		in_valid = 1'b0;
		while (sb.expected_words.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic configure(input int hl, input int rd, input bit il, input bit neg,
			input logic [23:0] step);
		wait_drained();
		write_reg(REG_HEAD_LENGTH, CFG_DATA_BITS'(hl));
		write_reg(REG_ROTARY_DIMS, CFG_DATA_BITS'(rd));
		write_reg(REG_INTERLEAVED, CFG_DATA_BITS'(il));
		write_reg(REG_NEGATE_SINE, CFG_DATA_BITS'(neg));
		write_reg(REG_FREQ_STEP, step);
		phases_run++;
	endtask

	function automatic logic [15:0] random_sample();
		case ($urandom_range(0, 7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_rows(input int rows);
		rope_in_t w;
		for (int r = 0; r < rows; r++) begin
			w.position = ($urandom_range(0, 5) == 0) ? 16'hFFFF : 16'($urandom);
			for (int i = 0; i < sb.row_len(); i++) begin
				w.in_value = random_sample();
				send_word(w);
			end
		end
	endtask

	task automatic send_directed_row(input logic [15:0] pos);
		logic [15:0] vals[8];
		rope_in_t w;
		vals = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0001,
			16'h7FFF, 16'h7FFF, 16'h8000, 16'hFFFF};
		w.position = pos;
		for (int i = 0; i < sb.row_len(); i++) begin
			w.in_value = vals[i % 8];
			send_word(w);
		end
	endtask

	initial begin
		int hl, rd, hle, rde;
		bit il;
		logic [23:0] step;
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_word = '0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		items_sent = 0;
		phases_run = 0;
		idle_cycles = 0;
		no_gaps = 0;
		long_hold = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: split pairs with extreme values and positions
		configure(8, 8, 0, 0, 24'd435413);
		send_directed_row(16'hFFFF);
		send_directed_row(16'h0000);
		// interleaved, inverse rotation, largest frequency step
		configure(6, 4, 1, 1, 24'hFFFFFF);
		send_directed_row(16'hFFFF);
		// no rotation at all, and a zero step
		configure(3, 0, 0, 1, 24'd0);
		send_directed_row(16'h1234);
		// head length below the minimum, odd rotary dims above it
		configure(0, 255, 0, 0, 24'd435413);
		send_directed_row(16'hFFFF);

		// widest row, full rotation, receiver holds off while the sender presses on
		configure(255, 128, 0, 0, 24'd435413);
		long_hold = 1;
		send_rows(1);
		configure(128, 128, 1, 1, 24'($urandom));
		no_gaps = 1;
		send_rows(1);
		no_gaps = 0;

		while (items_sent < 550) begin
			hl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(2, 20);
			rd = $urandom_range(0, 22);
			il = $urandom_range(0, 1);
			hle = (hl < 2) ? 2 : ((hl > 128) ? 128 : hl);
			rde = rd & ~1;
			if (rde > hle) rde = hle;
			// split pairing on an odd count would read a never written first half
			if (!il && (rde % 2)) rd = hle - 1;
			case ($urandom_range(0, 3))
				0: step = 24'd0;
				1: step = 24'hFFFFFF;
				2: step = 24'd435413;
				default: step = 24'($urandom);
			endcase
			configure(hl, rd, il, $urandom_range(0, 1), step);
			no_gaps = ($urandom_range(0, 4) == 0);
			send_rows(hle > 40 ? 1 : $urandom_range(2, 4));
		end
		no_gaps = 0;

		in_valid = 1'b0;
		while (sb.expected_words.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("covered %0d input words over %0d register settings", items_sent, phases_run);
		$display("checked %0d result words, %0d rotated pairs",
			sb.words_checked, sb.pairs_rotated);
		if (sb.errors == 0 && sb.expected_words.size() == 0)
			$display("[rotary_position_embedding_unit] OK");
		else
			$display("[rotary_position_embedding_unit] ERROR");
		$finish;
	end

endmodule
